// ===== rtl/mss_pkg.sv =====
// Shared types, codes and default sizes for the multi-stack shared store.
`timescale 1ns / 1ps

package mss_pkg;

  localparam int NumStacksDef = 8;
  localparam int CapacityDef  = 256;
  localparam int DataWidthDef = 32;

  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_POP  = 1'b1;

  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  typedef struct packed {
    logic               operation;
    logic [2:0]         stack_index;
    logic signed [31:0] value;
  } in_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] popped_value;
  } out_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DECODE,
    S_POP_WR
  } state_t;

  typedef struct packed {
    logic accept;
    logic read_pop;
    logic commit_push;
    logic commit_pop;
    logic commit_refuse;
  } cmd_t;

  typedef struct packed {
    logic is_pop;
    logic range_ok;
    logic top_ok;
    logic free_ok;
    logic out_busy;
  } stat_t;

endpackage

// ===== rtl/mss_ctrl.sv =====
// Controller state machine that sequences push and pop operations.
`timescale 1ns / 1ps

module mss_ctrl
  import mss_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   in_valid,
  output logic   in_stall,
  input  stat_t  stat,
  output cmd_t   cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        if (stat.is_pop && stat.range_ok && stat.top_ok) begin
          state_next = S_POP_WR;
        end else if (!stat.out_busy) begin
          state_next = S_IDLE;
        end
      end
      S_POP_WR: begin
        if (!stat.out_busy) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    case (state)
      S_IDLE: begin
        in_stall   = 1'b0;
        cmd.accept = in_valid;
      end
      S_DECODE: begin
        if (stat.is_pop && stat.range_ok && stat.top_ok) begin
          // Fetch the top entry's link and data before unlinking it.
          cmd.read_pop = 1'b1;
        end else if (!stat.out_busy) begin
          if (!stat.is_pop && stat.range_ok && stat.free_ok) begin
            cmd.commit_push = 1'b1;
          end else begin
            cmd.commit_refuse = 1'b1;
          end
        end
      end
      S_POP_WR: begin
        cmd.commit_pop = !stat.out_busy;
      end
      default: begin
        cmd      = '0;
        in_stall = 1'b1;
      end
    endcase
  end

endmodule

// ===== rtl/mss_datapath.sv =====
// Datapath: data and link memories, stack tops, free-list head and result register.
`timescale 1ns / 1ps

module mss_datapath
  import mss_pkg::*;
#(
  parameter int NUM_STACKS = NumStacksDef,
  parameter int CAPACITY   = CapacityDef,
  parameter int DATA_WIDTH = DataWidthDef
) (
  input  logic  clk,
  input  logic  rst,
  input  in_t   in_data,
  output logic  out_valid,
  input  logic  out_stall,
  output out_t  out_data,
  input  cmd_t  cmd,
  output stat_t stat
);

  localparam int IDX_W  = $clog2(CAPACITY);
  localparam int CNT_W  = $clog2(CAPACITY + 1);
  localparam int TOP_AW = (NUM_STACKS > 1) ? $clog2(NUM_STACKS) : 1;
  localparam int SEL_W  = (TOP_AW > 3) ? TOP_AW : 3;

  // Link words carry a valid bit above the entry number; a cleared bit is null.
  logic [IDX_W:0]      link_mem [CAPACITY];
  logic [DATA_WIDTH-1:0] data_mem [CAPACITY];
  logic [IDX_W-1:0]    top_mem  [NUM_STACKS];
  logic [NUM_STACKS-1:0] top_vld;

  logic                  op_q;
  logic [TOP_AW-1:0]     sel_q;
  logic                  range_ok_q;
  logic [DATA_WIDTH-1:0] value_q;

  logic [IDX_W-1:0]      top_rd;
  logic                  top_rd_vld;
  logic [IDX_W:0]        link_rd;
  logic [IDX_W-1:0]      link_rd_addr;
  logic                  link_rd_fresh;
  logic [DATA_WIDTH-1:0] data_rd;

  logic [IDX_W-1:0]      fh_idx;
  logic                  fh_vld;
  logic [CNT_W-1:0]      fresh;

  logic [SEL_W-1:0]      sel_ext;
  logic [TOP_AW-1:0]     sel_in;
  logic [IDX_W-1:0]      link_addr;
  logic                  link_re;
  logic [CNT_W-1:0]      nxt_addr;
  logic [IDX_W:0]        link_eff;

  assign sel_ext   = SEL_W'(in_data.stack_index);
  assign sel_in    = sel_ext[TOP_AW-1:0];
  assign link_addr = cmd.read_pop ? top_rd : fh_idx;
  assign link_re   = cmd.accept || cmd.read_pop;

  // Entries at or above the fill mark were never taken and still link to the
  // next entry, as after reset.
  assign nxt_addr = CNT_W'(link_rd_addr) + CNT_W'(1);
  assign link_eff = link_rd_fresh ?
                    {(nxt_addr < CNT_W'(CAPACITY)), nxt_addr[IDX_W-1:0]} : link_rd;

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_q       <= in_data.operation;
      sel_q      <= sel_in;
      range_ok_q <= (32'(in_data.stack_index) < NUM_STACKS);
      value_q    <= DATA_WIDTH'($unsigned(in_data.value));
      top_rd     <= top_mem[sel_in];
      top_rd_vld <= top_vld[sel_in];
    end
  end

  always_ff @(posedge clk) begin
    if (link_re) begin
      link_rd       <= link_mem[link_addr];
      link_rd_addr  <= link_addr;
      link_rd_fresh <= (CNT_W'(link_addr) >= fresh);
    end
    if (cmd.read_pop) begin
      data_rd <= data_mem[top_rd];
    end
    if (cmd.commit_push) begin
      link_mem[fh_idx] <= {top_rd_vld, top_rd};
      data_mem[fh_idx] <= value_q;
    end else if (cmd.commit_pop) begin
      link_mem[top_rd] <= {fh_vld, fh_idx};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit_push) begin
      top_mem[sel_q] <= fh_idx;
    end else if (cmd.commit_pop) begin
      top_mem[sel_q] <= link_eff[IDX_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      top_vld <= '0;
      fh_idx  <= '0;
      fh_vld  <= 1'b1;
      fresh   <= '0;
    end else if (cmd.commit_push) begin
      top_vld[sel_q] <= 1'b1;
      fh_idx         <= link_eff[IDX_W-1:0];
      fh_vld         <= link_eff[IDX_W];
      if (link_rd_fresh) begin
        fresh <= fresh + CNT_W'(1);
      end
    end else if (cmd.commit_pop) begin
      top_vld[sel_q] <= link_eff[IDX_W];
      fh_idx         <= top_rd;
      fh_vld         <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.commit_push || cmd.commit_pop || cmd.commit_refuse) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit_push) begin
      out_data.status       <= ST_DONE;
      out_data.popped_value <= '0;
    end else if (cmd.commit_pop) begin
      out_data.status       <= ST_DONE;
      out_data.popped_value <= 32'(data_rd);
    end else if (cmd.commit_refuse) begin
      out_data.status       <= (op_q == OP_POP) ? ST_EMPTY : ST_FULL;
      out_data.popped_value <= '0;
    end
  end

  assign stat.is_pop   = (op_q == OP_POP);
  assign stat.range_ok = range_ok_q;
  assign stat.top_ok   = top_rd_vld;
  assign stat.free_ok  = fh_vld;
  assign stat.out_busy = out_valid && out_stall;

endmodule

// ===== rtl/multi_stack_shared_store.sv =====
// A push or a refused operation is accepted in IDLE and its result is committed in DECODE;
// a successful pop also needs POP_WR, as its link and data reads wait for the stack top read.
// One word is in flight at a time, so a new word is accepted only after the last is committed.
// The result register lets the next word be accepted while a result waits to be taken.
// Synchronous reset empties every stack and restores the free chain at once; no clearing pass.
`timescale 1ns / 1ps

module multi_stack_shared_store
  import mss_pkg::*;
#(
  parameter int NUM_STACKS = NumStacksDef,
  parameter int CAPACITY   = CapacityDef,
  parameter int DATA_WIDTH = DataWidthDef
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_stall,
  output out_t out_data
);

  cmd_t  cmd;
  stat_t stat;

  mss_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  mss_datapath #(
    .NUM_STACKS (NUM_STACKS),
    .CAPACITY   (CAPACITY),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cmd       (cmd),
    .stat      (stat)
  );

endmodule

// ===== rtl/mss_checker.sv =====
// Port-level checks for the multi-stack shared store, bound to the top level.
`timescale 1ns / 1ps

module mss_checker
  import mss_pkg::*;
(
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_stall,
  input in_t  in_data,
  input logic out_valid,
  input logic out_stall,
  input out_t out_data
);

  // A stalled result word stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result word dropped while stalled");

  // Only one word is worked on at a time.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input accepted while a word is in progress");

  // Refused operations return no data.
  a_refuse_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_data.status != ST_DONE) |-> out_data.popped_value == '0)
    else $error("refused operation returned data");

  // With the result register empty, an accepted push is committed in DECODE without waiting.
  a_push_latency: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && (in_data.operation == OP_PUSH) && !out_valid
    |-> ##2 out_valid)
    else $error("push result late");

endmodule

bind multi_stack_shared_store mss_checker u_mss_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

// ===== verif/tb_top.sv =====
// Self-checking testbench for the multi-stack shared store, with directed and random words.
`timescale 1ns / 1ps

module tb_top;
  import mss_pkg::*;

  localparam int NUM_STACKS = NumStacksDef;
  localparam int CAPACITY = CapacityDef;
  localparam int DATA_WIDTH = DataWidthDef;
  localparam int PTR_W = $clog2(CAPACITY);
  localparam int IDLE_LIMIT = 2000;
  localparam int SETTLE_CYCLES = 12;
  localparam int LONG_HOLD = 80;
  localparam int MAX_REPORTS = 10;
  localparam int NUM_PHASES = 4;

  // One entry reference: ok cleared means null.
  typedef struct packed {
    logic             ok;
    logic [PTR_W-1:0] at;
  } slot_ref_t;

  typedef struct packed {
    logic        op;
    logic [2:0]  stack;
    logic [31:0] value;
    logic        fixed;
    logic [1:0]  status;
    logic [31:0] popped;
  } stim_row_t;

  // Rows with fixed set carry the answer typed in; the others are predicted.
  localparam stim_row_t DIRECTED_ROWS [20] = '{
    '{OP_POP,  3'd0, 32'h0000_0000, 1'b1, ST_EMPTY, 32'h0000_0000},
    '{OP_POP,  3'd7, 32'h0000_0000, 1'b1, ST_EMPTY, 32'h0000_0000},
    '{OP_PUSH, 3'd0, 32'h7FFF_FFFF, 1'b1, ST_DONE,  32'h0000_0000},
    '{OP_PUSH, 3'd0, 32'h8000_0000, 1'b1, ST_DONE,  32'h0000_0000},
    '{OP_PUSH, 3'd7, 32'h0000_0000, 1'b1, ST_DONE,  32'h0000_0000},
    '{OP_PUSH, 3'd7, 32'hFFFF_FFFF, 1'b1, ST_DONE,  32'h0000_0000},
    '{OP_PUSH, 3'd3, 32'hA5A5_A5A5, 1'b0, ST_DONE,  32'h0000_0000},
    '{OP_POP,  3'd0, 32'h0000_0000, 1'b1, ST_DONE,  32'h8000_0000},
    '{OP_POP,  3'd0, 32'h0000_0000, 1'b1, ST_DONE,  32'h7FFF_FFFF},
    '{OP_POP,  3'd0, 32'h0000_0000, 1'b1, ST_EMPTY, 32'h0000_0000},
    '{OP_POP,  3'd7, 32'h0000_0000, 1'b1, ST_DONE,  32'hFFFF_FFFF},
    '{OP_PUSH, 3'd4, 32'h5A5A_5A5A, 1'b0, ST_DONE,  32'h0000_0000},
    '{OP_PUSH, 3'd3, 32'h0000_FFFF, 1'b0, ST_DONE,  32'h0000_0000},
    '{OP_POP,  3'd3, 32'hDEAD_BEEF, 1'b0, ST_DONE,  32'h0000_0000},
    '{OP_POP,  3'd3, 32'h0000_0000, 1'b0, ST_DONE,  32'h0000_0000},
    '{OP_POP,  3'd7, 32'h0000_0000, 1'b0, ST_DONE,  32'h0000_0000},
    '{OP_POP,  3'd3, 32'h0000_0000, 1'b1, ST_EMPTY, 32'h0000_0000},
    '{OP_POP,  3'd4, 32'h0000_0000, 1'b0, ST_DONE,  32'h0000_0000},
    '{OP_POP,  3'd4, 32'h1234_5678, 1'b1, ST_EMPTY, 32'h0000_0000},
    '{OP_POP,  3'd7, 32'h0000_0000, 1'b1, ST_EMPTY, 32'h0000_0000}
  };

  logic clk;
  logic rst;
  logic in_valid;
  logic in_stall;
  in_t  in_data;
  logic out_valid;
  logic out_stall;
  out_t out_data;

  // Shadow copy of the store, the stack tops and the free chain.
  logic [DATA_WIDTH-1:0] shadow_data [CAPACITY];
  slot_ref_t shadow_link [CAPACITY];
  slot_ref_t shadow_top [NUM_STACKS];
  slot_ref_t shadow_free;

  out_t pending_results [$];
  out_t oldest_result;
  int   mismatch_count = 0;
  int   results_seen = 0;
  int   results_taken = 0;
  int   idle_cycles = 0;
  bit   send_calm = 1'b0;
  bit   recv_calm = 1'b0;

  multi_stack_shared_store uut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic out_t predict_stack_op(in_t w);
    out_t             r;
    logic [PTR_W-1:0] e;
    r = '{status: ST_DONE, popped_value: '0};
    if (w.operation == OP_PUSH) begin
      if (int'(w.stack_index) >= NUM_STACKS || !shadow_free.ok) begin
        r.status = ST_FULL;
      end else begin
        e = shadow_free.at;
        shadow_free = shadow_link[e];
        shadow_data[e] = w.value[DATA_WIDTH-1:0];
        shadow_link[e] = shadow_top[w.stack_index];
        shadow_top[w.stack_index] = '{ok: 1'b1, at: e};
      end
    end else begin
      if (int'(w.stack_index) >= NUM_STACKS || !shadow_top[w.stack_index].ok) begin
        r.status = ST_EMPTY;
      end else begin
        e = shadow_top[w.stack_index].at;
        shadow_top[w.stack_index] = shadow_link[e];
        r.popped_value = 32'(shadow_data[e]);
        shadow_link[e] = shadow_free;
        shadow_free = '{ok: 1'b1, at: e};
      end
    end
    return r;
  endfunction

  function automatic in_t random_word(int push_pct);
    in_t w;
    w.operation = ($urandom_range(0, 99) < push_pct) ? OP_PUSH : OP_POP;
    w.stack_index = 3'($urandom_range(0, NUM_STACKS - 1));
    case ($urandom_range(0, 9))
      0: w.value = 32'h8000_0000;
      1: w.value = 32'h7FFF_FFFF;
      2: w.value = 32'h0000_0000;
      3: w.value = 32'hFFFF_FFFF;
      default: w.value = $urandom;
    endcase
    return w;
  endfunction

  // Offers one word after a random gap and records its answer once it is taken.
  task automatic send_word(in_t w, bit fixed, out_t fixed_result);
    int   gap;
    out_t predicted;
    gap = send_calm ? 0 : $urandom_range(0, 5);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= w;
    do @(posedge clk); while (in_stall);
    predicted = predict_stack_op(w);
    pending_results.push_back(fixed ? fixed_result : predicted);
  endtask

  task automatic pause_until_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
  endtask

  initial begin
    int   push_pct [NUM_PHASES];
    int   phase_len [NUM_PHASES];
    in_t  stim;
    out_t fixed_result;
    push_pct = '{50, 95, 5, 50};
    phase_len = '{150, 320, 320, 310};
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      shadow_data[i] = '0;
      shadow_link[i] = '{ok: (i + 1 < CAPACITY), at: PTR_W'(i + 1)};
    end
    for (int s = 0; s < NUM_STACKS; s++) shadow_top[s] = '0;
    shadow_free = '{ok: 1'b1, at: '0};
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (DIRECTED_ROWS[i]) begin
      stim = '{operation: DIRECTED_ROWS[i].op, stack_index: DIRECTED_ROWS[i].stack,
               value: DIRECTED_ROWS[i].value};
      fixed_result = '{status: DIRECTED_ROWS[i].status, popped_value: DIRECTED_ROWS[i].popped};
      send_word(stim, DIRECTED_ROWS[i].fixed, fixed_result);
    end
    pause_until_drained();

    // Mixed traffic, then a fill past full, then a drain past empty, then mixed again.
    for (int p = 0; p < NUM_PHASES; p++) begin
      for (int k = 0; k < phase_len[p]; k++) begin
        if (k % 64 == 0) send_calm = ($urandom_range(0, 3) == 0);
        send_word(random_word(push_pct[p]), 1'b0, '0);
      end
      pause_until_drained();
    end

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

  // Result side: random stalls per word, with two long hold-offs so the block backs up.
  initial begin
    int hold;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (results_taken % 64 == 0) recv_calm = ($urandom_range(0, 3) == 0);
      if (results_taken == 100 || results_taken == 600) begin
        hold = LONG_HOLD;
      end else begin
        hold = recv_calm ? 0 : $urandom_range(0, 5);
      end
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(negedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (rst || !out_valid);
      results_taken++;
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      idle_cycles <= 0;
    end else if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end

    if (!rst && out_valid && !out_stall) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS) begin
          $display("result %0d: unexpected word, status %0d popped 0x%08h",
                   results_seen, out_data.status, out_data.popped_value);
        end
      end else begin
        oldest_result = pending_results.pop_front();
        if (out_data.status !== oldest_result.status ||
            out_data.popped_value !== oldest_result.popped_value) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS) begin
            $display("result %0d: expected status %0d popped 0x%08h, got status %0d popped 0x%08h",
                     results_seen, oldest_result.status, oldest_result.popped_value,
                     out_data.status, out_data.popped_value);
          end
        end
      end
    end
  end

  initial begin
    do @(posedge clk); while (idle_cycles < IDLE_LIMIT);
    $display("tb_top: FAIL");
    $finish;
  end

endmodule
